// ===== rtl/cbq_pkg.sv =====
`timescale 1ns / 1ps

package cbq_pkg;

  // Default sizes of the filter.
  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 20;

  // Fixed field and port widths.
  localparam int SLOT_W    = 6;
  localparam int CFG_W     = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int COEFS_PER_SECTION = 5;

  // Position of each coefficient inside a section's group of five.
  localparam int K_B0 = 0;
  localparam int K_B1 = 1;
  localparam int K_B2 = 2;
  localparam int K_A1 = 3;
  localparam int K_A2 = 4;

  // Input commands.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Register index of sections_in_use, as taken from paddr[2].
  localparam logic REG_SECTIONS = 1'b0;
  localparam logic [CFG_W-1:0] SECTIONS_RESET = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // One section takes six steps, five named after the coefficient read issued and one for the row write.
  typedef enum logic [2:0] {
    PH_RD_A1,
    PH_RD_A2,
    PH_RD_B1,
    PH_RD_B2,
    PH_RD_B0,
    PH_WRITE
  } phase_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_SUB,
    ACC_X_SUB,
    ACC_LOAD
  } acc_op_e;

  typedef enum logic [1:0] {
    MUL_D1,
    MUL_D2,
    MUL_W
  } mul_sel_e;

  typedef struct packed {
    acc_op_e  acc_op;
    mul_sel_e mul_sel;
    logic     x_load_in;
    logic     x_load_round;
    logic     w_load;
  } mac_ctrl_t;

endpackage

// ===== rtl/cbq_coef_ram.sv =====
`timescale 1ns / 1ps

module cbq_coef_ram #(
  parameter int DEPTH = 40,
  parameter int WIDTH = 20,
  parameter int AW    = 6
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cbq_delay_ram.sv =====
`timescale 1ns / 1ps

module cbq_delay_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 48,
  parameter int AW    = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [DEPTH-1:0] valid_q;
  logic             rvalid_q;

  // A row never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/cbq_mac.sv =====
`timescale 1ns / 1ps

module cbq_mac #(
  parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = cbq_pkg::COEF_WIDTH
) (
  input  logic                            clk_i,
  input  cbq_pkg::mac_ctrl_t              ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  logic signed [COEF_WIDTH-1:0]    coef_i,
  input  logic signed [SAMPLE_WIDTH+7:0]  d1_i,
  input  logic signed [SAMPLE_WIDTH+7:0]  d2_i,
  output logic signed [SAMPLE_WIDTH+7:0]  w_o,
  output logic signed [SAMPLE_WIDTH-1:0]  y_o
);

  localparam int DW     = SAMPLE_WIDTH + 8;
  localparam int FRAC   = COEF_WIDTH - 4;
  localparam int PROD_W = COEF_WIDTH + DW;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] D_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] D_LO = ~D_HI;
  localparam logic signed [DW-1:0] Y_HI = {{(DW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [DW-1:0] Y_LO = ~Y_HI;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DW-1:0]     x_q, w_q;
  logic signed [DW-1:0]     opnd;
  logic signed [ACC_W-1:0]  prod_ext, x_ext, acc_rnd, acc_shr;
  logic signed [DW-1:0]     rnd_sat;

  always_comb begin
    case (ctrl_i.mul_sel)
      cbq_pkg::MUL_D2: opnd = d2_i;
      cbq_pkg::MUL_W:  opnd = w_q;
      default:         opnd = d1_i;
    endcase
  end

  assign prod_ext = ACC_W'(prod_q);
  assign x_ext    = ACC_W'(x_q) <<< FRAC;

  always_comb begin
    case (ctrl_i.acc_op)
      cbq_pkg::ACC_ADD:   acc_d = acc_q + prod_ext;
      cbq_pkg::ACC_SUB:   acc_d = acc_q - prod_ext;
      cbq_pkg::ACC_X_SUB: acc_d = x_ext - prod_ext;
      cbq_pkg::ACC_LOAD:  acc_d = prod_ext;
      default:            acc_d = acc_q;
    endcase
  end

  // Round half up, floor shift back to delay word scale, then saturate.
  always_comb begin
    acc_rnd = acc_q + RND_HALF;
    acc_shr = acc_rnd >>> FRAC;
    if (acc_shr > D_HI) begin
      rnd_sat = D_HI[DW-1:0];
    end else if (acc_shr < D_LO) begin
      rnd_sat = D_LO[DW-1:0];
    end else begin
      rnd_sat = acc_shr[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(coef_i) * PROD_W'(opnd);
    acc_q  <= acc_d;
    if (ctrl_i.x_load_in) begin
      x_q <= DW'(sample_i);
    end else if (ctrl_i.x_load_round) begin
      x_q <= rnd_sat;
    end
    if (ctrl_i.w_load) begin
      w_q <= rnd_sat;
    end
  end

  assign w_o = w_q;

  always_comb begin
    if (x_q > Y_HI) begin
      y_o = Y_HI[SAMPLE_WIDTH-1:0];
    end else if (x_q < Y_LO) begin
      y_o = Y_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_o = x_q[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/cascaded_biquad_iir_filter.sv =====
`timescale 1ns / 1ps

// Cascade of direct-form-II biquad sections on signed fixed-point samples.
// Input channel (in_valid_i/in_ready_o): each word is a command. A load word
// writes coef_value_i into coefficient slot coef_slot_i (section*5 + k) and is
// taken with no result, leaving the block idle; slots beyond the store are
// dropped. A filter word runs sample_in_i through n = min(sections_in_use,
// MAX_SECTIONS) sections and yields one word on the output channel
// (out_valid_o/out_ready_i). One shared multiplier forms five products per
// section, with coefficients and delay rows fetched from synchronous
// memories, one read per cycle from each. A new filter word is taken only
// after the last result is in the output register; in_ready_o is low while a
// sample is in flight.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and computed, and is held until the register frees.
// Reset clears the delay words (per-row valid bits, no clearing pass) and
// sets sections_in_use to 1. Coefficients are undefined until loaded and are
// never cleared; loading them leaves the delay words alone. sections_in_use
// must be written by the user via APB address 0 while idle (not enforced).
module cascaded_biquad_iir_filter #(
  parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS,
  parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = cbq_pkg::COEF_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  logic [cbq_pkg::SLOT_W-1:0]        coef_slot_i,
  input  logic signed [COEF_WIDTH-1:0]      coef_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbq_pkg::APB_AW-1:0]        paddr,
  input  logic [cbq_pkg::APB_DW-1:0]        pwdata,
  output logic [cbq_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int DW         = SAMPLE_WIDTH + 8;
  localparam int COEF_DEPTH = cbq_pkg::COEFS_PER_SECTION * MAX_SECTIONS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int SEC_W      = $clog2(MAX_SECTIONS + 1);
  localparam int ROW_AW     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SLOT_EXT_W = (CA_W > cbq_pkg::SLOT_W) ? CA_W : cbq_pkg::SLOT_W;

  cbq_pkg::state_e   state_q, state_d;
  cbq_pkg::phase_e   phase_q, phase_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic [cbq_pkg::CFG_W-1:0] cfg_sections_q;
  logic              out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic [SEC_W-1:0]  n_active;
  logic              in_fire, out_load;
  logic              cfg_we;
  cbq_pkg::mac_ctrl_t mac_ctrl;

  logic [SLOT_EXT_W-1:0] slot_ext;
  logic              coef_we, coef_re;
  logic [CA_W-1:0]   coef_base, coef_raddr;
  logic signed [COEF_WIDTH-1:0] coef_rdata;

  logic              row_re, row_we;
  logic [2*DW-1:0]   row_rdata, row_wdata;
  logic signed [DW-1:0] d1, d2, w_val;
  logic signed [SAMPLE_WIDTH-1:0] y_val;

  // ---------------------------------------------------------------- config
  assign cfg_we = psel && penable && pwrite && (paddr[2] == cbq_pkg::REG_SECTIONS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cbq_pkg::REG_SECTIONS) ?
                  cbq_pkg::APB_DW'(cfg_sections_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sections_q <= cbq_pkg::SECTIONS_RESET;
    end else if (cfg_we) begin
      cfg_sections_q <= pwdata[cbq_pkg::CFG_W-1:0];
    end
  end

  assign n_active = (5'(cfg_sections_q) > 5'(MAX_SECTIONS)) ?
                    SEC_W'(MAX_SECTIONS) : SEC_W'(cfg_sections_q);

  // ---------------------------------------------------------------- memories
  assign in_fire  = in_valid_i && in_ready_o;
  assign slot_ext = SLOT_EXT_W'(coef_slot_i);
  assign coef_we  = in_fire && (command_i == cbq_pkg::CMD_LOAD) &&
                    (slot_ext < SLOT_EXT_W'(COEF_DEPTH));
  assign coef_base = (CA_W'(sec_q) << 2) + CA_W'(sec_q);

  cbq_coef_ram #(
    .DEPTH (COEF_DEPTH),
    .WIDTH (COEF_WIDTH),
    .AW    (CA_W)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (slot_ext[CA_W-1:0]),
    .wdata_i (coef_value_i),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Row layout: newest delay word in the upper half.
  assign d1        = row_rdata[2*DW-1:DW];
  assign d2        = row_rdata[DW-1:0];
  assign row_wdata = {w_val, d1};

  cbq_delay_ram #(
    .DEPTH (MAX_SECTIONS),
    .WIDTH (2 * DW),
    .AW    (ROW_AW)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (row_we),
    .waddr_i (sec_q[ROW_AW-1:0]),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (sec_q[ROW_AW-1:0]),
    .rdata_o (row_rdata)
  );

  // ---------------------------------------------------------------- datapath
  cbq_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_in_i),
    .coef_i   (coef_rdata),
    .d1_i     (d1),
    .d2_i     (d2),
    .w_o      (w_val),
    .y_o      (y_val)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbq_pkg::ST_IDLE;
      phase_q     <= cbq_pkg::PH_RD_A1;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= y_val;
    end
  end

  // The tail of section s (adding b0*w, rounding y) overlaps the first two
  // steps of section s+1; a pass with sec_q equal to n only runs that tail.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    sec_d      = sec_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    coef_re    = 1'b0;
    coef_raddr = coef_base + CA_W'(cbq_pkg::K_A1);
    row_re     = 1'b0;
    row_we     = 1'b0;
    mac_ctrl   = '{acc_op: cbq_pkg::ACC_HOLD, mul_sel: cbq_pkg::MUL_D1,
                   x_load_in: 1'b0, x_load_round: 1'b0, w_load: 1'b0};

    unique case (state_q)
      cbq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (command_i == cbq_pkg::CMD_FILTER)) begin
          mac_ctrl.x_load_in = 1'b1;
          sec_d   = '0;
          phase_d = cbq_pkg::PH_RD_A1;
          state_d = cbq_pkg::ST_RUN;
        end
      end

      cbq_pkg::ST_RUN: begin
        unique case (phase_q)
          cbq_pkg::PH_RD_A1: begin
            coef_re    = (sec_q < n_active);
            row_re     = (sec_q < n_active);
            coef_raddr = coef_base + CA_W'(cbq_pkg::K_A1);
            if (sec_q != '0) begin
              mac_ctrl.acc_op = cbq_pkg::ACC_ADD;
            end
            phase_d = cbq_pkg::PH_RD_A2;
          end
          cbq_pkg::PH_RD_A2: begin
            coef_re    = (sec_q < n_active);
            coef_raddr = coef_base + CA_W'(cbq_pkg::K_A2);
            mac_ctrl.mul_sel      = cbq_pkg::MUL_D1;
            mac_ctrl.x_load_round = (sec_q != '0);
            if (sec_q == n_active) begin
              state_d = cbq_pkg::ST_DONE;
              phase_d = cbq_pkg::PH_RD_A1;
            end else begin
              phase_d = cbq_pkg::PH_RD_B1;
            end
          end
          cbq_pkg::PH_RD_B1: begin
            coef_re    = 1'b1;
            coef_raddr = coef_base + CA_W'(cbq_pkg::K_B1);
            mac_ctrl.mul_sel = cbq_pkg::MUL_D2;
            mac_ctrl.acc_op  = cbq_pkg::ACC_X_SUB;
            phase_d = cbq_pkg::PH_RD_B2;
          end
          cbq_pkg::PH_RD_B2: begin
            coef_re    = 1'b1;
            coef_raddr = coef_base + CA_W'(cbq_pkg::K_B2);
            mac_ctrl.mul_sel = cbq_pkg::MUL_D1;
            mac_ctrl.acc_op  = cbq_pkg::ACC_SUB;
            phase_d = cbq_pkg::PH_RD_B0;
          end
          cbq_pkg::PH_RD_B0: begin
            coef_re    = 1'b1;
            coef_raddr = coef_base + CA_W'(cbq_pkg::K_B0);
            mac_ctrl.mul_sel = cbq_pkg::MUL_D2;
            mac_ctrl.acc_op  = cbq_pkg::ACC_LOAD;
            mac_ctrl.w_load  = 1'b1;
            phase_d = cbq_pkg::PH_WRITE;
          end
          cbq_pkg::PH_WRITE: begin
            mac_ctrl.mul_sel = cbq_pkg::MUL_W;
            mac_ctrl.acc_op  = cbq_pkg::ACC_ADD;
            row_we  = 1'b1;
            sec_d   = sec_q + 1'b1;
            phase_d = cbq_pkg::PH_RD_A1;
          end
          default: begin
            phase_d = cbq_pkg::PH_RD_A1;
          end
        endcase
      end

      cbq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = cbq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cbq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ===== rtl/cbq_checker.sv =====
`timescale 1ns / 1ps

module cbq_checker #(
  parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    command_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                    pready
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("result word dropped or changed while stalled");

  // A filter word keeps the block busy through at least the PH_RD_A1 and PH_RD_A2 steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == cbq_pkg::CMD_FILTER)
    |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon after a filter word");

  // A coefficient load finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == cbq_pkg::CMD_LOAD) |=> in_ready_o)
    else $error("coefficient load stalled the input");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a sample in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind cascaded_biquad_iir_filter cbq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cbq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .command_i    (command_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .pready       (pready)
);

// ===== bench/tb_cascaded_biquad_iir_filter.sv =====
`timescale 1ns / 1ps

module tb_cascaded_biquad_iir_filter;

  localparam int SAMPLE_WIDTH      = cbq_pkg::SAMPLE_WIDTH;
  localparam int COEF_WIDTH        = cbq_pkg::COEF_WIDTH;
  localparam int MAX_SECTIONS      = cbq_pkg::MAX_SECTIONS;
  localparam int COEFS_PER_SECTION = cbq_pkg::COEFS_PER_SECTION;
  localparam int SLOT_W            = cbq_pkg::SLOT_W;
  localparam int CFG_W             = cbq_pkg::CFG_W;
  localparam int APB_AW            = cbq_pkg::APB_AW;
  localparam int APB_DW            = cbq_pkg::APB_DW;

  localparam int DELAY_W       = SAMPLE_WIDTH + 8;
  localparam int COEF_FRAC     = COEF_WIDTH - 4;
  localparam int NUM_SLOTS     = COEFS_PER_SECTION * MAX_SECTIONS;
  localparam int UNITY         = 1 << COEF_FRAC;
  localparam int SAMPLE_MAX    = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int SAMPLE_MIN    = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int COEF_MAX      = 2 ** (COEF_WIDTH - 1) - 1;
  localparam int COEF_MIN      = -(2 ** (COEF_WIDTH - 1));
  localparam int SETTLE_CYCLES = 6 * MAX_SECTIONS + 13;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 1700;
  localparam int CALM_TAIL     = 200;
  localparam logic [APB_AW-1:0] SECTIONS_ADDR =
    APB_AW'(4 * int'(cbq_pkg::REG_SECTIONS));

  typedef struct {
    logic                           cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [SLOT_W-1:0]              slot;
    logic signed [COEF_WIDTH-1:0]   value;
  } filter_word_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic                           command_i    = cbq_pkg::CMD_FILTER;
  logic signed [SAMPLE_WIDTH-1:0] sample_in_i  = '0;
  logic [SLOT_W-1:0]              coef_slot_i  = '0;
  logic signed [COEF_WIDTH-1:0]   coef_value_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b1;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_o;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [APB_AW-1:0]              paddr        = '0;
  logic [APB_DW-1:0]              pwdata       = '0;
  logic [APB_DW-1:0]              prdata;
  logic                           pready;

  // Mirror of the filter state.
  logic [CFG_W-1:0]               sections_cfg = cbq_pkg::SECTIONS_RESET;
  logic signed [DELAY_W-1:0]      delay_line [2*MAX_SECTIONS] = '{default: '0};
  logic signed [COEF_WIDTH-1:0]   coef_bank [NUM_SLOTS] = '{default: '0};

  logic signed [SAMPLE_WIDTH-1:0] due_samples [$];
  int unsigned                    mismatches   = 0;
  int unsigned                    quiet_cycles = 0;
  int unsigned                    stall_left   = 0;
  int unsigned                    words        = 0;
  bit                             gaps_on      = 1'b1;

  cascaded_biquad_iir_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .sample_in_i (sample_in_i),
    .coef_slot_i (coef_slot_i),
    .coef_value_i(coef_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_to(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Round half up, drop the coefficient fraction and saturate to a delay word.
  function automatic longint round_to_delay(input longint acc);
    return clamp_to((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, DELAY_W);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] cascade_response(
    input logic signed [SAMPLE_WIDTH-1:0] sample
  );
    longint x, w, acc, d1, d2;
    int     n, base;
    n = (sections_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections_cfg);
    x = sample;
    for (int s = 0; s < n; s++) begin
      base = s * COEFS_PER_SECTION;
      d1   = delay_line[2*s];
      d2   = delay_line[2*s+1];
      acc  = (x <<< COEF_FRAC) - longint'(coef_bank[base + cbq_pkg::K_A1]) * d1
             - longint'(coef_bank[base + cbq_pkg::K_A2]) * d2;
      w    = round_to_delay(acc);
      acc  = longint'(coef_bank[base + cbq_pkg::K_B0]) * w
             + longint'(coef_bank[base + cbq_pkg::K_B1]) * d1
             + longint'(coef_bank[base + cbq_pkg::K_B2]) * d2;
      x    = round_to_delay(acc);
      delay_line[2*s+1] = delay_line[2*s];
      delay_line[2*s]   = DELAY_W'(w);
    end
    return SAMPLE_WIDTH'(clamp_to(x, SAMPLE_WIDTH));
  endfunction

  // Well-behaved coefficients keep every section stable; wild ones span the field.
  function automatic int pick_coef(input int k, input bit wild);
    logic signed [COEF_WIDTH-1:0] v;
    int                           m;
    if (wild) begin
      v = COEF_WIDTH'($urandom());
      return v;
    end
    case (k)
      cbq_pkg::K_A1: m = 39321;
      cbq_pkg::K_A2: m = 19660;
      default:       m = 49152;
    endcase
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic filter_word_t random_word(input bit wild);
    filter_word_t w;
    int unsigned  r;
    w.cmd    = cbq_pkg::CMD_FILTER;
    w.sample = SAMPLE_WIDTH'($urandom());
    w.slot   = SLOT_W'($urandom());
    w.value  = COEF_WIDTH'($urandom());
    r = $urandom_range(0, 99);
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0:       w.sample = SAMPLE_WIDTH'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
        1:       w.sample = SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
        default: ;
      endcase
    end else if (r < 95) begin
      w.cmd   = cbq_pkg::CMD_LOAD;
      w.slot  = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      w.value = COEF_WIDTH'(pick_coef(w.slot % COEFS_PER_SECTION, wild));
    end else begin
      w.cmd  = cbq_pkg::CMD_LOAD;
      w.slot = SLOT_W'($urandom_range(NUM_SLOTS, 2 ** SLOT_W - 1));
    end
    return w;
  endfunction

  task automatic send_word(input filter_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= w.cmd;
    sample_in_i  <= w.sample;
    coef_slot_i  <= w.slot;
    coef_value_i <= w.value;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.cmd == cbq_pkg::CMD_LOAD) begin
      if (w.slot < NUM_SLOTS) coef_bank[w.slot] = w.value;
    end else begin
      due_samples.push_back(cascade_response(w.sample));
    end
  endtask

  task automatic load_coef(input int slot, input int value);
    filter_word_t w;
    w.cmd    = cbq_pkg::CMD_LOAD;
    w.sample = SAMPLE_WIDTH'($urandom());
    w.slot   = SLOT_W'(slot);
    w.value  = COEF_WIDTH'(value);
    send_word(w);
  endtask

  task automatic filter_sample(input int sample);
    filter_word_t w;
    w.cmd    = cbq_pkg::CMD_FILTER;
    w.sample = SAMPLE_WIDTH'(sample);
    w.slot   = SLOT_W'($urandom());
    w.value  = COEF_WIDTH'($urandom());
    send_word(w);
  endtask

  // Wait until every sample has come out, then leave a quiet gap before the
  // register is touched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sections(input int unsigned n);
    logic [APB_DW-1:0] data;
    data             = $urandom();
    data[CFG_W-1:0]  = CFG_W'(n);
    psel            <= 1'b1;
    penable         <= 1'b0;
    pwrite          <= 1'b1;
    paddr           <= SECTIONS_ADDR;
    pwdata          <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    sections_cfg  = data[CFG_W-1:0];
  endtask

  task automatic test_identity_and_extremes();
    // Section 0 as a plain wire: b0 is one and the rest are zero.
    load_coef(cbq_pkg::K_B0, UNITY);
    load_coef(cbq_pkg::K_B1, 0);
    load_coef(cbq_pkg::K_B2, 0);
    load_coef(cbq_pkg::K_A1, 0);
    load_coef(cbq_pkg::K_A2, 0);
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    filter_sample(0);
    filter_sample(-1);
    filter_sample(1);
  endtask

  task automatic test_section_saturation();
    // Maximum gain with strong positive feedback drives the delay words to
    // their limits within a few samples.
    load_coef(cbq_pkg::K_B0, COEF_MAX);
    load_coef(cbq_pkg::K_A1, COEF_MIN);
    filter_sample(SAMPLE_MIN);
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MAX);
    filter_sample(12345);
  endtask

  task automatic test_ignored_slots();
    load_coef(2 ** SLOT_W - 1, COEF_MAX);
    load_coef(NUM_SLOTS, COEF_MIN);
    filter_sample(100);
  endtask

  task automatic test_zero_sections();
    settle();
    write_sections(0);
    filter_sample(SAMPLE_MIN);
    filter_sample(SAMPLE_MAX);
    filter_sample(5);
  endtask

  task automatic test_random_phases();
    int unsigned  plan [6] = '{8, 15, 9, 1, 0, 3};
    int unsigned  phase, n_cfg, active;
    bit           wild;
    filter_word_t w;
    phase = 0;
    while (words < RANDOM_WORDS) begin
      n_cfg  = (phase < 6) ? plan[phase] : $urandom_range(0, 15);
      wild   = ($urandom_range(0, 3) == 0);
      settle();
      gaps_on = (phase % 4 != 3) && (words < RANDOM_WORDS - CALM_TAIL);
      write_sections(n_cfg);
      // Every section in use gets a full set before its first sample.
      active = (n_cfg > MAX_SECTIONS) ? MAX_SECTIONS : n_cfg;
      for (int s = 0; s < active * COEFS_PER_SECTION; s++) begin
        load_coef(s, pick_coef(s % COEFS_PER_SECTION, wild));
        words++;
      end
      repeat ($urandom_range(40, 120)) begin
        w = random_word(wild);
        send_word(w);
        if (w.cmd == cbq_pkg::CMD_FILTER || w.slot < NUM_SLOTS) words++;
      end
      phase++;
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(1, 6);
      out_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_samples.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: sample_out_o = %0d with no sample pending", $time, sample_out_o);
        end
        mismatches++;
      end else begin
        want = due_samples.pop_front();
        if (sample_out_o !== want) begin
          if (mismatches < 10) begin
            $display("%0t: sample_out_o mismatch: expected %0d, got %0d",
                     $time, want, sample_out_o);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_identity_and_extremes();
    test_section_saturation();
    test_ignored_slots();
    test_zero_sections();
    test_random_phases();
    in_valid_i <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cbq_pkg.sv
rtl/cbq_coef_ram.sv
rtl/cbq_delay_ram.sv
rtl/cbq_mac.sv
rtl/cascaded_biquad_iir_filter.sv
rtl/cbq_checker.sv
bench/tb_cascaded_biquad_iir_filter.sv
